/* src/asc_pkg.sv */
package asc_pkg;

  localparam int IN_W          = 16;
  localparam int OUT_W         = 18;
  // sigma(n) < 8n for any n below 2^32, so three extra bits hold the full sum
  localparam int ACC_W         = IN_W + 3;
  localparam int NUM_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    L_IDLE,
    L_TEST,
    L_DIV,
    L_ACC,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic [IN_W-1:0]  num;
    logic [ACC_W-1:0] sum;
  } lane_res_t;

endpackage

/* src/asc_lane.sv */
module asc_lane import asc_pkg::*; #(
  parameter int W = NUM_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] n_in,
  output logic         idle,
  output logic         res_valid,
  input  logic         res_ready,
  output lane_res_t    res
);

  localparam int SW = W + 3;
  localparam int CW = $clog2(W);

  lane_state_t   state, state_next;
  logic [W-1:0]  n;
  logic [W-1:0]  d;
  logic [W:0]    sq;
  logic [SW-1:0] total;
  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [CW-1:0] cnt;

  logic [W:0]    trial;
  logic          borrow;

  // one restoring-division step per cycle: n / d
  assign trial  = {rem, q[W-1]} - {1'b0, d};
  assign borrow = trial[W];

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE: if (start) state_next = L_TEST;
      L_TEST: state_next = (sq <= {1'b0, n}) ? L_DIV : L_DONE;
      L_DIV:  if (cnt == '0) state_next = L_ACC;
      L_ACC:  state_next = L_TEST;
      L_DONE: if (res_ready) state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      L_IDLE: idle = 1'b1;
      L_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.num = IN_W'(n);
  assign res.sum = ACC_W'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: begin
        if (start) begin
          n     <= n_in;
          d     <= W'(1);
          sq    <= (W+1)'(1);
          total <= '0;
        end
      end
      L_TEST: begin
        rem <= '0;
        q   <= n;
        cnt <= CW'(W - 1);
        // loop over: turn sigma(n) into the aliquot sum
        if (sq > {1'b0, n}) total <= total - SW'(n);
      end
      L_DIV: begin
        if (borrow) begin
          rem <= {rem[W-2:0], q[W-1]};
          q   <= {q[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end
        cnt <= cnt - CW'(1);
      end
      L_ACC: begin
        // divisor pair d, n/d; count a square root once
        if (rem == '0) begin
          total <= total + SW'(d) + ((q != d) ? SW'(q) : '0);
        end
        d  <= d + W'(1);
        sq <= sq + {d, 1'b1};
      end
      L_DONE: ;
      default: ;
    endcase
  end

  a_square_tracks: assert property (@(posedge clk) disable iff (rst)
    state == L_TEST |-> (2*W)'(sq) == (2*W)'(d) * (2*W)'(d))
    else $error("candidate square out of step with candidate");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    state == L_DIV && cnt == '0 |=> state == L_ACC)
    else $error("division did not finish after W steps");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == L_ACC |-> rem < d)
    else $error("remainder not below divisor");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == L_DONE && !res_ready |=> state == L_DONE && $stable(total))
    else $error("lane result dropped before merge");

endmodule

/* src/asc_merge.sv */
module asc_merge import asc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lane_res_t        a_res,
  input  lane_res_t        b_res,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] first_sum,
  output logic [OUT_W-1:0] second_sum,
  output logic             first_perfect,
  output logic             first_abundant,
  output logic             pair_amicable,
  output logic             pair_friendly
);

  localparam int PW = ACC_W + IN_W;

  logic             s1_valid;
  logic [IN_W-1:0]  s1_a, s1_b;
  logic [ACC_W-1:0] s1_sa, s1_sb;
  logic [PW-1:0]    s1_p1, s1_p2;
  logic             s1_take;

  assign s1_take  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_take) out_valid <= s1_valid;
    end
  end

  // stage 1: cross products for the abundancy compare
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_a  <= a_res.num;
      s1_b  <= b_res.num;
      s1_sa <= a_res.sum;
      s1_sb <= b_res.sum;
      s1_p1 <= PW'(a_res.sum) * PW'(b_res.num);
      s1_p2 <= PW'(b_res.sum) * PW'(a_res.num);
    end
  end

  // stage 2: sums and flags into the output register
  always_ff @(posedge clk) begin
    if (s1_take && s1_valid) begin
      first_sum      <= s1_sa[OUT_W-1:0];
      second_sum     <= s1_sb[OUT_W-1:0];
      first_perfect  <= (s1_a != '0) && (s1_sa == ACC_W'(s1_a));
      first_abundant <= s1_sa > ACC_W'(s1_a);
      pair_amicable  <= (ACC_W'(s1_a) == s1_sb) && (ACC_W'(s1_b) == s1_sa);
      pair_friendly  <= (s1_a != '0) && (s1_b != '0) && (s1_p1 == s1_p2);
    end
  end

endmodule

/* src/aliquot_sum_classifier_core.sv */
// Each lane walks divisor candidates up to sqrt(n); each candidate costs one
// iterative division of min(NUM_WIDTH, IN_W) steps plus a test and an accumulate state.
// Throughput: one request at a time through the lanes; a new request is taken
// while the previous result still waits in the output register.
// Reset (rst, synchronous): lanes return to idle, merge and output stages empty.
module aliquot_sum_classifier_core import asc_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  first_number,
  input  logic [IN_W-1:0]  second_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] first_sum,
  output logic [OUT_W-1:0] second_sum,
  output logic             first_perfect,
  output logic             first_abundant,
  output logic             pair_amicable,
  output logic             pair_friendly
);

  localparam int EW = (NUM_WIDTH < IN_W) ? NUM_WIDTH : IN_W;

  logic      start;
  logic      a_idle, b_idle;
  logic      a_valid, b_valid;
  logic      m_valid, m_ready;
  lane_res_t a_res, b_res;

  assign in_ready = a_idle && b_idle;
  assign start    = in_valid && in_ready;
  assign m_valid  = a_valid && b_valid;

  asc_lane #(.W(EW)) u_lane_a (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .n_in      (first_number[EW-1:0]),
    .idle      (a_idle),
    .res_valid (a_valid),
    .res_ready (m_valid && m_ready),
    .res       (a_res)
  );

  asc_lane #(.W(EW)) u_lane_b (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .n_in      (second_number[EW-1:0]),
    .idle      (b_idle),
    .res_valid (b_valid),
    .res_ready (m_valid && m_ready),
    .res       (b_res)
  );

  asc_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (m_valid),
    .in_ready       (m_ready),
    .a_res          (a_res),
    .b_res          (b_res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .first_sum      (first_sum),
    .second_sum     (second_sum),
    .first_perfect  (first_perfect),
    .first_abundant (first_abundant),
    .pair_amicable  (pair_amicable),
    .pair_friendly  (pair_friendly)
  );

endmodule

/* bench/aliquot_sum_classifier_core_tb.sv */
module aliquot_sum_classifier_core_tb;
  import asc_pkg::*;

  localparam int NUM_W       = NUM_WIDTH_DEF;
  localparam int STALL_LIMIT = 50000;
  localparam int HOLD_CYCLES = 2000;
  localparam int RAND_ITEMS  = 100;
  localparam int N_KNOWN     = 10;

  typedef struct packed {
    logic [OUT_W-1:0] first_sum;
    logic [OUT_W-1:0] second_sum;
    logic             first_perfect;
    logic             first_abundant;
    logic             pair_amicable;
    logic             pair_friendly;
  } verdict_t;

  typedef struct {
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    bit              typed;
    verdict_t        v;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [IN_W-1:0]  first_number;
  logic [IN_W-1:0]  second_number;
  logic             out_valid;
  logic             out_ready;
  logic [OUT_W-1:0] first_sum;
  logic [OUT_W-1:0] second_sum;
  logic             first_perfect;
  logic             first_abundant;
  logic             pair_amicable;
  logic             pair_friendly;

  verdict_t pending_verdicts[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       hold_left = 0;
  bit       quiet = 1'b0;

  // perfect, amicable and friendly pairs below 2^16
  logic [IN_W-1:0] known_a [N_KNOWN] = '{16'd6, 16'd28, 16'd496, 16'd220, 16'd1184,
                                         16'd2620, 16'd5020, 16'd6232, 16'd10744, 16'd30};
  logic [IN_W-1:0] known_b [N_KNOWN] = '{16'd6, 16'd28, 16'd8128, 16'd284, 16'd1210,
                                         16'd2924, 16'd5564, 16'd6368, 16'd10856, 16'd140};

  aliquot_sum_classifier_core #(.NUM_WIDTH(NUM_W)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .first_number  (first_number),
    .second_number (second_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .first_sum     (first_sum),
    .second_sum    (second_sum),
    .first_perfect (first_perfect),
    .first_abundant(first_abundant),
    .pair_amicable (pair_amicable),
    .pair_friendly (pair_friendly)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned divisor_sum(longint unsigned n);
    longint unsigned total;
    longint unsigned d;
    total = 0;
    if (n < 2) return 0;
    for (d = 1; d * d <= n; d++) begin
      if (n % d == 0) begin
        total += d;
        if (n / d != d) total += n / d;
      end
    end
    return total - n;
  endfunction

  function automatic verdict_t classify_pair(logic [IN_W-1:0] a_in, logic [IN_W-1:0] b_in);
    longint unsigned a;
    longint unsigned b;
    longint unsigned sa;
    longint unsigned sb;
    verdict_t v;
    a = longint'(a_in) & ((64'd1 << NUM_W) - 1);
    b = longint'(b_in) & ((64'd1 << NUM_W) - 1);
    sa = divisor_sum(a);
    sb = divisor_sum(b);
    v.first_sum      = sa[OUT_W-1:0];
    v.second_sum     = sb[OUT_W-1:0];
    v.first_perfect  = (a != 0) && (sa == a);
    v.first_abundant = sa > a;
    v.pair_amicable  = (a == sb) && (b == sa);
    v.pair_friendly  = (a != 0) && (b != 0) && (sa * b == sb * a);
    return v;
  endfunction

  task automatic add_row(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b, input bit typed,
                         input int fs, input int ss, input bit fp, input bit fa,
                         input bit am, input bit fr);
    dir_row_t r;
    r.a = a;
    r.b = b;
    r.typed = typed;
    r.v = '{OUT_W'(fs), OUT_W'(ss), fp, fa, am, fr};
    dir_rows.push_back(r);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                              input verdict_t v);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    first_number  <= a;
    second_number <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(v);
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    int              mode;
    int              k;
    verdict_t        v;

    rst           <= 1'b1;
    in_valid      <= 1'b0;
    first_number  <= '0;
    second_number <= '0;

    add_row(16'd0,     16'd0,     1, 0,   0,   0, 0, 1, 0);
    add_row(16'd1,     16'd1,     1, 0,   0,   0, 0, 0, 1);
    add_row(16'd6,     16'd6,     1, 6,   6,   1, 0, 1, 1);
    add_row(16'd220,   16'd284,   1, 284, 220, 0, 1, 1, 0);
    add_row(16'd0,     16'd6,     1, 0,   6,   0, 0, 0, 0);
    add_row(16'd6,     16'd0,     1, 6,   0,   1, 0, 0, 0);
    add_row(16'd65535, 16'd65535, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'd65535, 16'd0,     0, 0, 0, 0, 0, 0, 0);
    add_row(16'd0,     16'd65535, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'd28,    16'd496,   0, 0, 0, 0, 0, 0, 0);
    add_row(16'd8128,  16'd8128,  0, 0, 0, 0, 0, 0, 0);
    add_row(16'd12,    16'd1,     0, 0, 0, 0, 0, 0, 0);
    add_row(16'd30,    16'd140,   0, 0, 0, 0, 0, 0, 0);
    add_row(16'd1184,  16'd1210,  0, 0, 0, 0, 0, 0, 0);
    add_row(16'd2,     16'd3,     0, 0, 0, 0, 0, 0, 0);
    add_row(16'd65521, 16'd65521, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'd12285, 16'd14595, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'd17296, 16'd18416, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'd65534, 16'd1,     0, 0, 0, 0, 0, 0, 0);
    add_row(16'd32768, 16'd32767, 0, 0, 0, 0, 0, 0, 0);
    add_row(16'd55440, 16'd12,    0, 0, 0, 0, 0, 0, 0);
    add_row(16'd496,   16'd28,    0, 0, 0, 0, 0, 0, 0);
    add_row(16'd5,     16'd5,     0, 0, 0, 0, 0, 0, 0);

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      v = dir_rows[i].typed ? dir_rows[i].v : classify_pair(dir_rows[i].a, dir_rows[i].b);
      send_request(dir_rows[i].a, dir_rows[i].b, v);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      mode = $urandom_range(99);
      quiet = (n >= 50 && n < 70);
      if (n == 10) hold_left = HOLD_CYCLES;
      if (n >= 10 && n < 20) begin
        // short requests so the block fills while the output is held off
        a = IN_W'($urandom_range(63));
        b = IN_W'($urandom_range(63));
      end else if (mode < 55) begin
        a = IN_W'($urandom_range(1023));
        b = IN_W'($urandom_range(1023));
      end else if (mode < 85) begin
        a = IN_W'($urandom);
        b = IN_W'($urandom);
      end else if (mode < 93) begin
        k = $urandom_range(N_KNOWN - 1);
        if ($urandom_range(1)) begin
          a = known_a[k];
          b = known_b[k];
        end else begin
          a = known_b[k];
          b = known_a[k];
        end
      end else begin
        case ($urandom_range(3))
          0: a = '0;
          1: a = 16'd1;
          2: a = '1;
          default: a = IN_W'($urandom);
        endcase
        b = ($urandom_range(1)) ? a : IN_W'($urandom);
      end
      send_request(a, b, classify_pair(a, b));
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side ready, with one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: first_sum %0d second_sum %0d", first_sum, second_sum);
        mismatches++;
      end else begin
        e = pending_verdicts.pop_front();
        if (first_sum !== e.first_sum) begin
          $error("first_sum: expected %0d, got %0d", e.first_sum, first_sum);
          mismatches++;
        end
        if (second_sum !== e.second_sum) begin
          $error("second_sum: expected %0d, got %0d", e.second_sum, second_sum);
          mismatches++;
        end
        if (first_perfect !== e.first_perfect) begin
          $error("first_perfect: expected %0d, got %0d", e.first_perfect, first_perfect);
          mismatches++;
        end
        if (first_abundant !== e.first_abundant) begin
          $error("first_abundant: expected %0d, got %0d", e.first_abundant, first_abundant);
          mismatches++;
        end
        if (pair_amicable !== e.pair_amicable) begin
          $error("pair_amicable: expected %0d, got %0d", e.pair_amicable, pair_amicable);
          mismatches++;
        end
        if (pair_friendly !== e.pair_friendly) begin
          $error("pair_friendly: expected %0d, got %0d", e.pair_friendly, pair_friendly);
          mismatches++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
  end

  // watchdog
  initial begin
    @(posedge clk);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/asc_pkg.sv
src/asc_lane.sv
src/asc_merge.sv
src/aliquot_sum_classifier_core.sv
bench/aliquot_sum_classifier_core_tb.sv
